FILE: src/etok_pkg.sv
// ----------------------------------------------------------------------------
// etok_pkg: shared types and helpers for the expression tokenizer
// Character classes, token and error codes, lexer modes and the beat
// formats passed between the tokenizer's stages.
// ----------------------------------------------------------------------------
package etok_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int CHAR_BITS         = 8;
  localparam int TOKEN_FIELD_BITS  = 16;
  localparam int KIND_BITS         = 4;
  localparam int ERROR_BITS        = 3;
  localparam int MAX_RESULTS       = 3;
  localparam int COUNT_BITS        = 2;

  localparam logic [CHAR_BITS-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CHAR_BITS-1:0] CH_LOWER_E    = 8'h65;
  localparam logic [CHAR_BITS-1:0] CH_UPPER_E    = 8'h45;
  localparam logic [CHAR_BITS-1:0] CH_DOT        = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_ZERO       = 8'h30;
  localparam logic [CHAR_BITS-1:0] CH_NINE       = 8'h39;
  localparam logic [CHAR_BITS-1:0] CH_PLUS       = 8'h2B;
  localparam logic [CHAR_BITS-1:0] CH_MINUS      = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_STAR       = 8'h2A;
  localparam logic [CHAR_BITS-1:0] CH_SLASH      = 8'h2F;
  localparam logic [CHAR_BITS-1:0] CH_CARET      = 8'h5E;
  localparam logic [CHAR_BITS-1:0] CH_LPAREN     = 8'h28;
  localparam logic [CHAR_BITS-1:0] CH_RPAREN     = 8'h29;

  typedef enum logic [KIND_BITS-1:0] {
    K_NUMBER = 4'd0,
    K_IDENT  = 4'd1,
    K_PLUS   = 4'd2,
    K_MINUS  = 4'd3,
    K_STAR   = 4'd4,
    K_SLASH  = 4'd5,
    K_CARET  = 4'd6,
    K_LPAREN = 4'd7,
    K_RPAREN = 4'd8,
    K_END    = 4'd9,
    K_ERROR  = 4'd10
  } kind_t;

  typedef enum logic [ERROR_BITS-1:0] {
    E_NONE         = 3'd0,
    E_LEADING_ZERO = 3'd1,
    E_BAD_FRACTION = 3'd2,
    E_BAD_EXPONENT = 3'd3,
    E_UNEXPECTED   = 3'd4
  } err_t;

  typedef enum logic [3:0] {
    M_IDLE,
    M_IDENT,
    M_ZERO,
    M_INT,
    M_DOT,
    M_FRAC,
    M_EXP,
    M_EXPSIGN,
    M_EXPDIG,
    M_ERROR
  } mode_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] code;
    logic                 present;
    logic                 end_mark;
  } item_t;

  typedef struct packed {
    kind_t                       kind;
    logic [TOKEN_FIELD_BITS-1:0] start;
    logic [TOKEN_FIELD_BITS-1:0] length;
    err_t                        err;
  } result_t;

  function automatic logic is_digit(input logic [CHAR_BITS-1:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

  function automatic logic is_alpha(input logic [CHAR_BITS-1:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  // Space, tab, line feed, vertical tab, form feed and carriage return.
  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic is_word(input logic [CHAR_BITS-1:0] c);
    return is_alpha(c) || is_digit(c) || (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_exp(input logic [CHAR_BITS-1:0] c);
    return (c == CH_LOWER_E) || (c == CH_UPPER_E);
  endfunction

  // Single-character operator tokens; anything else maps to K_ERROR.
  function automatic kind_t op_kind(input logic [CHAR_BITS-1:0] c);
    kind_t k;
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_CARET:  k = K_CARET;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default:   k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic result_t make_result(input kind_t kind,
                                          input logic [TOKEN_FIELD_BITS-1:0] start,
                                          input logic [TOKEN_FIELD_BITS-1:0] length,
                                          input err_t err);
    result_t r;
    r.kind   = kind;
    r.start  = start;
    r.length = length;
    r.err    = err;
    return r;
  endfunction

endpackage

FILE: src/etok_input_stage.sv
// ----------------------------------------------------------------------------
// etok_input_stage: input register with skid entry
// Holds the character beat that the lexer works on, plus one spare entry
// so that the input ready comes straight from a flop.
// ----------------------------------------------------------------------------
module etok_input_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  etok_pkg::item_t in_item,
  input  logic            take,
  output logic            item_valid,
  output etok_pkg::item_t item
);
  import etok_pkg::*;

  logic  main_valid;
  logic  skid_valid;
  item_t main_item;
  item_t skid_item;
  logic  accept;
  logic  main_free;

  assign in_ready   = !skid_valid;
  assign accept     = in_valid && in_ready;
  assign main_free  = !main_valid || take;
  assign item_valid = main_valid;
  assign item       = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      // The skid entry, when full, always goes first; ready is low then.
      main_valid <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      main_item <= skid_valid ? skid_item : in_item;
    end
    if (!main_free && accept) begin
      skid_item <= in_item;
    end
  end

endmodule

FILE: src/etok_lexer.sv
// ----------------------------------------------------------------------------
// etok_lexer: lexer state and single-pass token decode
// Holds the scan mode, the character position and the token origin, and
// decodes one character beat into up to three token results.
// ----------------------------------------------------------------------------
module etok_lexer #(
  parameter int POSITION_BITS = etok_pkg::POSITION_BITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         fire,
  input  etok_pkg::item_t                              item,
  output etok_pkg::result_t [etok_pkg::MAX_RESULTS-1:0] results,
  output logic [etok_pkg::COUNT_BITS-1:0]              count
);
  import etok_pkg::*;

  localparam int FB = TOKEN_FIELD_BITS;

  mode_t                    mode;
  logic [POSITION_BITS-1:0] pos;
  logic [POSITION_BITS-1:0] origin;

  mode_t                    mode_next;
  logic [POSITION_BITS-1:0] pos_next;
  logic [POSITION_BITS-1:0] origin_next;

  logic [POSITION_BITS-1:0] pos_prev;
  logic [POSITION_BITS-1:0] end_prev;
  logic [CHAR_BITS-1:0]     c;

  assign c        = item.code;
  assign pos_prev = (pos != '0) ? pos - 1'b1 : '0;

  always_comb begin
    mode_t                    m;
    logic [POSITION_BITS-1:0] org;
    logic [COUNT_BITS-1:0]    n;
    result_t [MAX_RESULTS-1:0] r;
    logic                     go_idle;
    kind_t                    op;

    m       = mode;
    org     = origin;
    n       = '0;
    r       = '0;
    go_idle = 1'b0;
    op      = op_kind(c);
    pos_next = pos;

    if (item.present && mode != M_ERROR) begin
      case (mode)
        M_IDLE: go_idle = 1'b1;
        M_IDENT: begin
          if (!is_word(c)) begin
            r[n] = make_result(K_IDENT, FB'(org), FB'(pos - org), E_NONE);
            n = n + 1'b1;
            m = M_IDLE;
            go_idle = 1'b1;
          end
        end
        M_ZERO, M_INT: begin
          if (is_digit(c)) begin
            if (mode == M_ZERO) begin
              r[n] = make_result(K_ERROR, FB'(org), '0, E_LEADING_ZERO);
              n = n + 1'b1;
              m = M_ERROR;
            end
          end else if (c == CH_DOT) begin
            m = M_DOT;
          end else if (is_exp(c)) begin
            m = M_EXP;
          end else begin
            r[n] = make_result(K_NUMBER, FB'(org), FB'(pos - org), E_NONE);
            n = n + 1'b1;
            m = M_IDLE;
            go_idle = 1'b1;
          end
        end
        M_DOT: begin
          if (is_digit(c)) begin
            m = M_FRAC;
          end else begin
            r[n] = make_result(K_ERROR, FB'(pos_prev), '0, E_BAD_FRACTION);
            n = n + 1'b1;
            m = M_ERROR;
          end
        end
        M_FRAC: begin
          if (is_exp(c)) begin
            m = M_EXP;
          end else if (!is_digit(c)) begin
            r[n] = make_result(K_NUMBER, FB'(org), FB'(pos - org), E_NONE);
            n = n + 1'b1;
            m = M_IDLE;
            go_idle = 1'b1;
          end
        end
        M_EXP: begin
          if (c == CH_PLUS || c == CH_MINUS) begin
            m = M_EXPSIGN;
          end else if (is_digit(c)) begin
            m = M_EXPDIG;
          end else begin
            r[n] = make_result(K_ERROR, FB'(pos_prev), '0, E_BAD_EXPONENT);
            n = n + 1'b1;
            m = M_ERROR;
          end
        end
        M_EXPSIGN: begin
          if (is_digit(c)) begin
            m = M_EXPDIG;
          end else begin
            r[n] = make_result(K_ERROR, FB'(pos_prev), '0, E_BAD_EXPONENT);
            n = n + 1'b1;
            m = M_ERROR;
          end
        end
        M_EXPDIG: begin
          if (!is_digit(c)) begin
            r[n] = make_result(K_NUMBER, FB'(org), FB'(pos - org), E_NONE);
            n = n + 1'b1;
            m = M_IDLE;
            go_idle = 1'b1;
          end
        end
        default: ;
      endcase

      // The closing character, if any, starts the next token here.
      if (go_idle) begin
        if (is_space(c)) begin
          m = M_IDLE;
        end else if (is_digit(c)) begin
          org = pos;
          m = (c == CH_ZERO) ? M_ZERO : M_INT;
        end else if (is_alpha(c) || c == CH_UNDERSCORE) begin
          org = pos;
          m = M_IDENT;
        end else if (op == K_ERROR) begin
          r[n] = make_result(K_ERROR, FB'(pos), '0, E_UNEXPECTED);
          n = n + 1'b1;
          m = M_ERROR;
        end else begin
          r[n] = make_result(op, FB'(pos), FB'(1), E_NONE);
          n = n + 1'b1;
        end
      end

      if (pos != '1) begin
        pos_next = pos + 1'b1;
      end
    end

    end_prev = (pos_next != '0) ? pos_next - 1'b1 : '0;

    if (item.end_mark) begin
      case (m)
        M_IDENT: begin
          r[n] = make_result(K_IDENT, FB'(org), FB'(pos_next - org), E_NONE);
          n = n + 1'b1;
          m = M_IDLE;
        end
        M_ZERO, M_INT, M_FRAC, M_EXPDIG: begin
          r[n] = make_result(K_NUMBER, FB'(org), FB'(pos_next - org), E_NONE);
          n = n + 1'b1;
          m = M_IDLE;
        end
        M_DOT: begin
          r[n] = make_result(K_ERROR, FB'(end_prev), '0, E_BAD_FRACTION);
          n = n + 1'b1;
          m = M_ERROR;
        end
        M_EXP, M_EXPSIGN: begin
          r[n] = make_result(K_ERROR, FB'(end_prev), '0, E_BAD_EXPONENT);
          n = n + 1'b1;
          m = M_ERROR;
        end
        default: ;
      endcase
      if (m != M_ERROR) begin
        r[n] = make_result(K_END, FB'(pos_next), '0, E_NONE);
        n = n + 1'b1;
      end
      m        = M_IDLE;
      pos_next = '0;
      org      = '0;
    end

    mode_next   = m;
    origin_next = org;
    results     = r;
    count       = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= M_IDLE;
      pos    <= '0;
      origin <= '0;
    end else if (fire) begin
      mode   <= mode_next;
      pos    <= pos_next;
      origin <= origin_next;
    end
  end

endmodule

FILE: src/etok_result_queue.sv
// ----------------------------------------------------------------------------
// etok_result_queue: result register for one character's tokens
// Loads all tokens of one character at once and hands them out one beat
// at a time, oldest first, flagging the last one.
// ----------------------------------------------------------------------------
module etok_result_queue (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          load,
  input  etok_pkg::result_t [etok_pkg::MAX_RESULTS-1:0] results,
  input  logic [etok_pkg::COUNT_BITS-1:0]               count,
  output logic                                          free,
  output logic                                          out_valid,
  input  logic                                          out_ready,
  output logic [etok_pkg::KIND_BITS-1:0]                token_kind,
  output logic [etok_pkg::TOKEN_FIELD_BITS-1:0]         token_start,
  output logic [etok_pkg::TOKEN_FIELD_BITS-1:0]         token_length,
  output logic [etok_pkg::ERROR_BITS-1:0]               error_kind,
  output logic                                          run_last
);
  import etok_pkg::*;

  result_t [MAX_RESULTS-1:0] entries;
  logic [COUNT_BITS-1:0]     fill;
  logic                      pop;

  assign out_valid    = (fill != '0);
  assign pop          = out_valid && out_ready;
  assign run_last     = (fill == COUNT_BITS'(1));
  // A new character may load when the queue is empty or when the last pending token leaves this cycle.
  assign free         = (fill == '0) || (run_last && out_ready);
  assign token_kind   = entries[0].kind;
  assign token_start  = entries[0].start;
  assign token_length = entries[0].length;
  assign error_kind   = entries[0].err;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (load) begin
      fill <= count;
    end else if (pop) begin
      fill <= fill - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entries <= results;
    end else if (pop) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        entries[i] <= entries[i+1];
      end
    end
  end

endmodule

FILE: src/expression_tokenizer.sv
// ----------------------------------------------------------------------------
// expression_tokenizer: streaming lexer for arithmetic expressions
// One character beat in, number/identifier/operator/paren/end/error
// tokens out, each with its start position and length.
// ----------------------------------------------------------------------------
// A character is accepted in any cycle that the input is ready, and its
// first token is presented at the earliest once it has passed the input
// register and been loaded into the result queue. Each character is
// decoded combinationally; a character that yields k tokens (at most
// three: a closed token, an operator and the end token) holds the single
// output port for k token beats, so the sustained rate is one character
// per cycle while the output is ready and characters yield at most one
// token each. Characters that yield nothing, such as those inside a
// number or identifier, load an empty token set into the result queue.
// The input keeps one spare entry, so its ready depends only on flops.
// After an error nothing is emitted until the next end mark, which emits
// no end token and returns the block to its reset state. Positions
// saturate at 2^POSITION_BITS-1 and are reported as their low 16 bits.
module expression_tokenizer #(
  parameter int POSITION_BITS = etok_pkg::POSITION_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [etok_pkg::CHAR_BITS-1:0]        char_code,
  input  logic                                  char_present,
  input  logic                                  end_mark,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [etok_pkg::KIND_BITS-1:0]        token_kind,
  output logic [etok_pkg::TOKEN_FIELD_BITS-1:0] token_start,
  output logic [etok_pkg::TOKEN_FIELD_BITS-1:0] token_length,
  output logic [etok_pkg::ERROR_BITS-1:0]       error_kind,
  output logic                                  run_last
);
  import etok_pkg::*;

  item_t                     in_item;
  item_t                     item;
  logic                      item_valid;
  logic                      queue_free;
  logic                      fire;
  result_t [MAX_RESULTS-1:0] results;
  logic [COUNT_BITS-1:0]     count;

  assign in_item.code     = char_code;
  assign in_item.present  = char_present;
  assign in_item.end_mark = end_mark;
  assign fire             = item_valid && queue_free;

  etok_input_stage u_input (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  etok_lexer #(
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (item),
    .results (results),
    .count   (count)
  );

  etok_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .load         (fire),
    .results      (results),
    .count        (count),
    .free         (queue_free),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .error_kind   (error_kind),
    .run_last     (run_last)
  );

endmodule

FILE: src/etok_checker.sv
// ----------------------------------------------------------------------------
// etok_checker: port-level checks for the expression tokenizer
// Watches the token channel and flags malformed or unstable beats.
// ----------------------------------------------------------------------------
module etok_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [etok_pkg::KIND_BITS-1:0]        token_kind,
  input logic [etok_pkg::TOKEN_FIELD_BITS-1:0] token_start,
  input logic [etok_pkg::TOKEN_FIELD_BITS-1:0] token_length,
  input logic [etok_pkg::ERROR_BITS-1:0]       error_kind,
  input logic                                  run_last
);
  import etok_pkg::*;

  // A stalled token beat holds its whole payload.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(token_kind)
      && $stable(token_start) && $stable(token_length)
      && $stable(error_kind) && $stable(run_last))
    else $error("token beat changed while stalled");

  // An error code travels only on error tokens, and always on them.
  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((token_kind == K_ERROR) == (error_kind != E_NONE)))
    else $error("error code does not match token kind");

  // End and error tokens carry no length and close their character's run.
  a_end_closes: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == K_END || token_kind == K_ERROR)
      |-> run_last && token_length == '0)
    else $error("end or error token is not a zero-length last beat");

  // Reset drops all pending tokens.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("token pending after reset");

endmodule

bind expression_tokenizer etok_checker u_checker (.*);

FILE: bench/tb_expression_tokenizer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expression_tokenizer: self-checking bench for the expression tokenizer
// Character beats go in through a bursty driver while the token port stalls
// on its own pattern. A behavioral lexer predicts every token at input
// acceptance, and a monitor compares each token beat against it in order.
// ----------------------------------------------------------------------------
module tb_expression_tokenizer;
  import etok_pkg::*;

  localparam logic [15:0] POS_MAX      = 16'hFFFF;
  localparam int          RANDOM_BEATS = 200;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          CYCLE_LIMIT  = 3_000_000;

  typedef struct {
    logic [7:0] code;
    logic       present;
    logic       ends;
    logic       hold;
  } char_beat_t;

  typedef struct {
    kind_t       kind;
    logic [15:0] start;
    logic [15:0] length;
    err_t        err;
    logic        last;
  } token_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_ready;
  logic [7:0]  char_code    = '0;
  logic        char_present = 1'b0;
  logic        end_mark     = 1'b0;
  logic        out_valid;
  logic        out_ready    = 1'b0;
  logic [3:0]  token_kind;
  logic [15:0] token_start;
  logic [15:0] token_length;
  logic [2:0]  error_kind;
  logic        run_last;

  char_beat_t  pending_beats[$];
  char_beat_t  next_beat;
  token_t      expected_tokens[$];
  token_t      step_tokens[$];
  logic [7:0]  text_buf[$];

  mode_t       lex_mode   = M_IDLE;
  logic [15:0] lex_pos    = '0;
  logic [15:0] tok_origin = '0;

  int          mismatches  = 0;
  int          cycle_count = 0;
  int          beat_count  = 0;
  int          burst_left  = 0;
  int          gap_left    = 0;
  logic [9:0]  stall_count = '0;
  logic        hold_next   = 1'b0;

  string word_chars  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  string op_chars    = "+-*/^()";
  string blank_chars = " \011\012\013\014\015";

  expression_tokenizer DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .char_code    (char_code),
    .char_present (char_present),
    .end_mark     (end_mark),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .token_kind   (token_kind),
    .token_start  (token_start),
    .token_length (token_length),
    .error_kind   (error_kind),
    .run_last     (run_last)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Lexer prediction
  // ---------------------------------------------------------------------------
  function automatic logic digit_ch(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic alpha_ch(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic blank_ch(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic word_ch(logic [7:0] c);
    return alpha_ch(c) || digit_ch(c) || c == CH_UNDERSCORE;
  endfunction

  function automatic logic [15:0] prev_pos(logic [15:0] p);
    return (p != 16'd0) ? p - 16'd1 : 16'd0;
  endfunction

  task automatic put_token(kind_t kind, logic [15:0] start, logic [15:0] len, err_t err);
    token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = len;
    t.err    = err;
    t.last   = 1'b0;
    step_tokens.insert(step_tokens.size(), t);
  endtask

  task automatic raise_error(err_t err, logic [15:0] where);
    put_token(K_ERROR, where, 16'd0, err);
    lex_mode = M_ERROR;
  endtask

  task automatic close_token(kind_t kind, logic [15:0] pos);
    put_token(kind, tok_origin, pos - tok_origin, E_NONE);
    lex_mode = M_IDLE;
  endtask

  task automatic start_token(logic [7:0] c, logic [15:0] pos);
    kind_t k;
    if (blank_ch(c)) return;
    if (digit_ch(c)) begin
      tok_origin = pos;
      lex_mode   = (c == CH_ZERO) ? M_ZERO : M_INT;
      return;
    end
    if (alpha_ch(c) || c == CH_UNDERSCORE) begin
      tok_origin = pos;
      lex_mode   = M_IDENT;
      return;
    end
    case (c)
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_CARET:  k = K_CARET;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      default: begin
        raise_error(E_UNEXPECTED, pos);
        return;
      end
    endcase
    put_token(k, pos, 16'd1, E_NONE);
  endtask

  // A character that cannot extend the open token closes it and is then
  // lexed again as the start of the next token.
  task automatic scan_char(logic [7:0] c, logic [15:0] pos);
    logic is_e;
    is_e = (c == CH_LOWER_E) || (c == CH_UPPER_E);
    case (lex_mode)
      M_IDLE: begin
        start_token(c, pos);
        return;
      end
      M_IDENT: begin
        if (word_ch(c)) return;
        close_token(K_IDENT, pos);
      end
      M_ZERO, M_INT: begin
        if (digit_ch(c)) begin
          if (lex_mode == M_ZERO) raise_error(E_LEADING_ZERO, tok_origin);
          return;
        end
        if (c == CH_DOT) begin
          lex_mode = M_DOT;
          return;
        end
        if (is_e) begin
          lex_mode = M_EXP;
          return;
        end
        close_token(K_NUMBER, pos);
      end
      M_DOT: begin
        if (digit_ch(c)) lex_mode = M_FRAC;
        else raise_error(E_BAD_FRACTION, prev_pos(pos));
        return;
      end
      M_FRAC: begin
        if (digit_ch(c)) return;
        if (is_e) begin
          lex_mode = M_EXP;
          return;
        end
        close_token(K_NUMBER, pos);
      end
      M_EXP: begin
        if (c == CH_PLUS || c == CH_MINUS) lex_mode = M_EXPSIGN;
        else if (digit_ch(c)) lex_mode = M_EXPDIG;
        else raise_error(E_BAD_EXPONENT, prev_pos(pos));
        return;
      end
      M_EXPSIGN: begin
        if (digit_ch(c)) lex_mode = M_EXPDIG;
        else raise_error(E_BAD_EXPONENT, prev_pos(pos));
        return;
      end
      M_EXPDIG: begin
        if (digit_ch(c)) return;
        close_token(K_NUMBER, pos);
      end
      default: return;
    endcase
    start_token(c, pos);
  endtask

  task automatic end_text(logic [15:0] pos);
    case (lex_mode)
      M_IDENT:                        close_token(K_IDENT, pos);
      M_ZERO, M_INT, M_FRAC, M_EXPDIG: close_token(K_NUMBER, pos);
      M_DOT:                          raise_error(E_BAD_FRACTION, prev_pos(pos));
      M_EXP, M_EXPSIGN:               raise_error(E_BAD_EXPONENT, prev_pos(pos));
      default: ;
    endcase
    // A text that ended in error gets no end token.
    if (lex_mode != M_ERROR) put_token(K_END, pos, 16'd0, E_NONE);
  endtask

  task automatic predict_beat(logic [7:0] c, logic present, logic ends);
    step_tokens.delete();
    if (present && lex_mode != M_ERROR) begin
      scan_char(c, lex_pos);
      if (lex_pos != POS_MAX) lex_pos = lex_pos + 16'd1;
    end
    if (ends) begin
      end_text(lex_pos);
      lex_mode   = M_IDLE;
      lex_pos    = '0;
      tok_origin = '0;
    end
    if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
  endtask

  task automatic check_token();
    token_t want;
    if (expected_tokens.size() == 0) begin
      $error("unexpected token beat: kind %0d start %0d length %0d",
             token_kind, token_start, token_length);
      mismatches++;
      return;
    end
    want = expected_tokens.pop_front();
    if (token_kind !== want.kind) begin
      $error("token_kind: expected %0d, got %0d", want.kind, token_kind);
      mismatches++;
    end
    if (token_start !== want.start) begin
      $error("token_start: expected %0d, got %0d", want.start, token_start);
      mismatches++;
    end
    if (token_length !== want.length) begin
      $error("token_length: expected %0d, got %0d", want.length, token_length);
      mismatches++;
    end
    if (error_kind !== want.err) begin
      $error("error_kind: expected %0d, got %0d", want.err, error_kind);
      mismatches++;
    end
    if (run_last !== want.last) begin
      $error("run_last: expected %0d, got %0d", want.last, run_last);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_valid || in_ready) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_beats.size() == 0 ||
                   (pending_beats[0].hold && (in_valid || expected_tokens.size() != 0))) begin
        in_valid <= 1'b0;
      end else begin
        next_beat = pending_beats.pop_front();
        in_valid     <= 1'b1;
        char_code    <= next_beat.code;
        char_present <= next_beat.present;
        end_mark     <= next_beat.ends;
        if (burst_left == 0) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                    : $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 5) == 0) ? $urandom_range(5, 12)
                                                    : $urandom_range(0, 3);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready   <= 1'b0;
      stall_count <= '0;
    end else begin
      stall_count <= stall_count + 10'd1;
      case (stall_count[9:8])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= ($urandom_range(0, 1) == 0);
        2'd2: out_ready <= (stall_count[2:0] == 3'd0);
        default: out_ready <= (stall_count[4:0] < 5'd20);
      endcase
    end
  end

  // Prediction and checking share one process so that a token beat never
  // races the character beat that caused it.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) predict_beat(char_code, char_present, end_mark);
      if (out_valid && out_ready) check_token();
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic add_beat(logic [7:0] code, logic present, logic ends);
    char_beat_t b;
    b.code    = code;
    b.present = present;
    b.ends    = ends;
    b.hold    = hold_next;
    hold_next = 1'b0;
    pending_beats.insert(pending_beats.size(), b);
    if (present || ends) beat_count++;
  endtask

  task automatic add_text(string s, logic end_on_last);
    for (int i = 0; i < s.len(); i++)
      add_beat(s[i], 1'b1, end_on_last && (i == s.len() - 1));
  endtask

  task automatic add_blank();
    add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  task automatic add_bare_end();
    add_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic append_char(logic [7:0] ch);
    text_buf.insert(text_buf.size(), ch);
  endtask

  task automatic push_digits(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++) append_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_exp_mark();
    append_char($urandom_range(0, 1) ? CH_LOWER_E : CH_UPPER_E);
  endtask

  task automatic push_number();
    if ($urandom_range(0, 7) == 0) begin
      append_char(CH_ZERO);
    end else begin
      append_char(CH_ZERO + 8'($urandom_range(1, 9)));
      push_digits(0, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      append_char(CH_DOT);
      push_digits(1, 3);
    end
    if ($urandom_range(0, 2) == 0) begin
      push_exp_mark();
      case ($urandom_range(0, 2))
        0: append_char(CH_PLUS);
        1: append_char(CH_MINUS);
        default: ;
      endcase
      push_digits(1, 2);
    end
  endtask

  // Number prefixes that are malformed or go wrong depending on what follows them.
  task automatic push_broken_number();
    case ($urandom_range(0, 3))
      0: begin
        append_char(CH_ZERO);
        push_digits(1, 2);
      end
      1: begin
        push_digits(1, 2);
        append_char(CH_DOT);
      end
      2: begin
        push_digits(1, 2);
        push_exp_mark();
      end
      default: begin
        push_digits(1, 2);
        push_exp_mark();
        append_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      end
    endcase
  endtask

  task automatic push_token();
    int pick;
    int n;
    pick = $urandom_range(0, 19);
    if (pick <= 5) begin
      push_number();
    end else if (pick <= 9) begin
      append_char(word_chars[$urandom_range(0, 52)]);
      n = $urandom_range(0, 4);
      for (int i = 0; i < n; i++)
        append_char(word_chars[$urandom_range(0, word_chars.len() - 1)]);
    end else if (pick <= 14) begin
      append_char(op_chars[$urandom_range(0, op_chars.len() - 1)]);
    end else if (pick <= 17) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        append_char(blank_chars[$urandom_range(0, blank_chars.len() - 1)]);
    end else if (pick == 18) begin
      append_char(8'($urandom_range(0, 255)));
    end else begin
      push_broken_number();
    end
    // Keep most numbers and names apart so that texts are mostly well formed.
    if (pick <= 9 && $urandom_range(0, 1) == 0)
      append_char(blank_chars[$urandom_range(0, blank_chars.len() - 1)]);
  endtask

  task automatic random_text();
    int   ntok;
    logic end_on_char;
    text_buf.delete();
    ntok        = $urandom_range(0, 6);
    end_on_char = $urandom_range(0, 1);
    for (int i = 0; i < ntok; i++) push_token();
    if ($urandom_range(0, 19) == 0) hold_next = 1'b1;
    foreach (text_buf[i]) begin
      if ($urandom_range(0, 15) == 0) add_blank();
      add_beat(text_buf[i], 1'b1, end_on_char && (i == text_buf.size() - 1));
    end
    if (!end_on_char || text_buf.size() == 0) add_bare_end();
  endtask

  initial begin
    // Directed texts: every operator, number shapes, each error kind,
    // an empty beat, a bare end mark and the byte extremes.
    add_text("0.5e+3", 1'b0);
    add_blank();
    add_text("*(x_1)", 1'b1);
    add_text("9^Z+1-/", 1'b0);
    add_bare_end();
    add_text("00", 1'b1);
    add_text("1.", 1'b1);
    add_text("2e", 1'b1);
    add_beat(8'hFF, 1'b1, 1'b1);
    add_beat(8'h00, 1'b1, 1'b1);

    // The first random text waits until every earlier token has come back.
    beat_count = 0;
    hold_next  = 1'b1;
    while (beat_count < RANDOM_BEATS) random_text();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_beats.size() != 0 || in_valid || expected_tokens.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
